// ===== sv/imd_pkg.sv =====
package imd_pkg;

   localparam int WORD_BITS_DEF = 32;
   localparam int FRAC_BITS_DEF = 16;

   typedef enum logic {
      OP_MUL = 1'b0,
      OP_DIV = 1'b1
   } op_type;

   // side information that travels with a word through the product stages
   typedef struct packed {
      logic valid;
      logic ov;
      logic dz;
   } ctl_type;

endpackage

// ===== sv/imd_recip.sv =====
module imd_recip #(
   parameter int WORD_BITS = 32,
   parameter int FRAC_BITS = 16
) (
   input  logic                        clock,
   input  logic                        en,
   input  logic signed [WORD_BITS-1:0] b,
   output logic signed [WORD_BITS-1:0] recip,
   output logic                        ov
);
   import imd_pkg::*;

   localparam int NQ = 2 * FRAC_BITS + 1;
   localparam int QW = 2 * FRAC_BITS + 2;
   localparam int RW = WORD_BITS + 1;
   localparam int CW = ((QW > WORD_BITS) ? QW : WORD_BITS) + 1;

   logic [WORD_BITS-1:0] mag_ff, mag_in;
   logic                 neg_ff;

   logic [RW-1:0]        rem_ff [NQ];
   logic [QW-1:0]        quo_ff [NQ];
   logic [WORD_BITS-1:0] div_ff [NQ];
   logic                 sgn_ff [NQ];

   logic signed [WORD_BITS-1:0] recip_ff, recip_in;
   logic                        ov_ff, ov_in;

   logic [CW-1:0] q_fix, lim, mag_sat;

   assign mag_in = b[WORD_BITS-1] ? WORD_BITS'(-b) : WORD_BITS'(b);

   always_ff @(posedge clock) begin
      if (en) begin
         mag_ff <= mag_in;
         neg_ff <= b[WORD_BITS-1];
      end
   end

   // one quotient bit per stage; the dividend is a single one at bit 2F
   for (genvar g = 0; g < NQ; g++) begin : g_stage
      logic [RW-1:0]        r_prev, trial, r_in;
      logic [QW-1:0]        q_prev, q_in;
      logic [WORD_BITS-1:0] m_prev;
      logic                 n_prev, num_bit;

      if (g == 0) begin : g_first
         assign r_prev  = '0;
         assign q_prev  = '0;
         assign m_prev  = mag_ff;
         assign n_prev  = neg_ff;
         assign num_bit = 1'b1;
      end else begin : g_next
         assign r_prev  = rem_ff[g-1];
         assign q_prev  = quo_ff[g-1];
         assign m_prev  = div_ff[g-1];
         assign n_prev  = sgn_ff[g-1];
         assign num_bit = 1'b0;
      end

      always_comb begin
         trial = {r_prev[RW-2:0], num_bit};
         if (trial >= RW'(m_prev)) begin
            r_in = trial - RW'(m_prev);
            q_in = {q_prev[QW-2:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_prev[QW-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[g] <= r_in;
            quo_ff[g] <= q_in;
            div_ff[g] <= m_prev;
            sgn_ff[g] <= n_prev;
         end
      end
   end

   // round toward minus infinity for a negative divisor, then saturate
   always_comb begin
      q_fix = CW'(quo_ff[NQ-1]) + CW'(sgn_ff[NQ-1] && (rem_ff[NQ-1] != '0));
      lim   = sgn_ff[NQ-1] ? (CW'(1'b1) << (WORD_BITS - 1))
                           : (CW'(1'b1) << (WORD_BITS - 1)) - CW'(1'b1);
      ov_in   = q_fix > lim;
      mag_sat = ov_in ? lim : q_fix;
      recip_in = sgn_ff[NQ-1] ? -$signed(mag_sat[WORD_BITS-1:0])
                              : $signed(mag_sat[WORD_BITS-1:0]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         recip_ff <= recip_in;
         ov_ff    <= ov_in;
      end
   end

   assign recip = recip_ff;
   assign ov    = ov_ff;

endmodule

// ===== sv/imd_mul.sv =====
module imd_mul #(
   parameter int WORD_BITS = 32,
   parameter int FRAC_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  imd_pkg::ctl_type            ctl_in,
   input  logic signed [WORD_BITS-1:0] al,
   input  logic signed [WORD_BITS-1:0] ah,
   input  logic signed [WORD_BITS-1:0] bl,
   input  logic signed [WORD_BITS-1:0] bh,
   output imd_pkg::ctl_type            ctl_out,
   output logic signed [WORD_BITS-1:0] res_lo,
   output logic signed [WORD_BITS-1:0] res_hi
);
   import imd_pkg::*;

   localparam int PW = 2 * WORD_BITS;

   typedef struct packed {
      logic a_pos;
      logic a_neg;
      logic b_pos;
      logic b_neg;
   } sgn_type;

   // stage 1: four exact bound products
   ctl_type             c1_ff;
   sgn_type             s1_ff, s1_in;
   logic signed [PW-1:0] p01_ff, p10_ff, p00_ff, p11_ff;
   logic signed [PW-1:0] p01_in, p10_in, p00_in, p11_in;

   // stage 2: scaled and saturated products
   ctl_type                     c2_ff;
   sgn_type                     s2_ff;
   logic signed [WORD_BITS-1:0] v_ff [4];
   logic signed [WORD_BITS-1:0] v_in [4];
   logic                        o_ff [4];
   logic                        o_in [4];

   // stage 3: selected bounds
   ctl_type                     c3_ff, c3_in;
   logic signed [WORD_BITS-1:0] lo_ff, lo_in, hi_ff, hi_in;

   localparam int I01 = 0;
   localparam int I10 = 1;
   localparam int I00 = 2;
   localparam int I11 = 3;

   always_comb begin
      p01_in = al * bh;
      p10_in = ah * bl;
      p00_in = al * bl;
      p11_in = ah * bh;
      s1_in.a_pos = !al[WORD_BITS-1];
      s1_in.a_neg = ah[WORD_BITS-1] || (ah == '0);
      s1_in.b_pos = !bl[WORD_BITS-1];
      s1_in.b_neg = bh[WORD_BITS-1] || (bh == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c1_ff.valid <= 1'b0;
      end else if (en) begin
         c1_ff.valid <= ctl_in.valid;
      end
      if (en) begin
         c1_ff.ov <= ctl_in.ov;
         c1_ff.dz <= ctl_in.dz;
         s1_ff    <= s1_in;
         p01_ff   <= p01_in;
         p10_ff   <= p10_in;
         p00_ff   <= p00_in;
         p11_ff   <= p11_in;
      end
   end

   // arithmetic shift floors, which matches rounding toward minus infinity
   for (genvar g = 0; g < 4; g++) begin : g_scale
      logic signed [PW-1:0] prod, sh;
      assign prod = (g == I01) ? p01_ff : (g == I10) ? p10_ff :
                    (g == I00) ? p00_ff : p11_ff;
      always_comb begin
         sh = prod >>> FRAC_BITS;
         if ((sh[PW-1:WORD_BITS-1] == '0) || (sh[PW-1:WORD_BITS-1] == '1)) begin
            v_in[g] = sh[WORD_BITS-1:0];
            o_in[g] = 1'b0;
         end else begin
            v_in[g] = {sh[PW-1], {(WORD_BITS-1){!sh[PW-1]}}};
            o_in[g] = 1'b1;
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            v_ff[g] <= v_in[g];
            o_ff[g] <= o_in[g];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c2_ff.valid <= 1'b0;
      end else if (en) begin
         c2_ff.valid <= c1_ff.valid;
      end
      if (en) begin
         c2_ff.ov <= c1_ff.ov;
         c2_ff.dz <= c1_ff.dz;
         s2_ff    <= s1_ff;
      end
   end

   always_comb begin
      int il, ih;
      il   = I00;
      ih   = I11;
      if (s2_ff.b_pos) begin
         if (s2_ff.a_pos) begin
            il = I00; ih = I11;
         end else if (s2_ff.a_neg) begin
            il = I01; ih = I10;
         end else begin
            il = I01; ih = I11;
         end
      end else if (s2_ff.b_neg) begin
         if (s2_ff.a_pos) begin
            il = I10; ih = I01;
         end else if (s2_ff.a_neg) begin
            il = I11; ih = I00;
         end else begin
            il = I10; ih = I00;
         end
      end else begin
         if (s2_ff.a_pos) begin
            il = I10; ih = I11;
         end else if (s2_ff.a_neg) begin
            il = I01; ih = I00;
         end else begin
            il = (v_ff[I01] < v_ff[I10]) ? I01 : I10;
            ih = (v_ff[I00] <= v_ff[I11]) ? I11 : I00;
         end
      end
      c3_in.valid = c2_ff.valid;
      c3_in.dz    = c2_ff.dz;
      if (c2_ff.dz) begin
         lo_in    = '0;
         hi_in    = '0;
         c3_in.ov = 1'b0;
      end else begin
         lo_in    = v_ff[il[1:0]];
         hi_in    = v_ff[ih[1:0]];
         c3_in.ov = c2_ff.ov || o_ff[il[1:0]] || o_ff[ih[1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c3_ff.valid <= 1'b0;
      end else if (en) begin
         c3_ff.valid <= c3_in.valid;
      end
      if (en) begin
         c3_ff.ov <= c3_in.ov;
         c3_ff.dz <= c3_in.dz;
         lo_ff    <= lo_in;
         hi_ff    <= hi_in;
      end
   end

   assign ctl_out = c3_ff;
   assign res_lo  = lo_ff;
   assign res_hi  = hi_ff;

`ifndef ASSERT_OFF
   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      c3_ff.valid && c3_ff.dz |-> lo_ff == '0 && hi_ff == '0 && !c3_ff.ov)
      else $error("divide by zero word carries nonzero bounds");
   a_ov_sat: assert property (@(posedge clock) disable iff (reset)
      en && c2_ff.valid && !c2_ff.dz && !c2_ff.ov && !o_ff[I00] && !o_ff[I01]
      && !o_ff[I10] && !o_ff[I11] |=> !c3_ff.ov)
      else $error("overflow raised without a saturated product");
`endif

endmodule

// ===== sv/interval_multiply_divide_top.sv =====
// Interval multiply / divide, signed fixed point (WORD_BITS wide, FRAC_BITS
// fraction bits, Q16.16 by default).
// Input channel req_*: one word per accepted handshake holding the opcode
// (multiply or divide) and two intervals [a_lo,a_hi], [b_lo,b_hi].
// Result channel rsp_*: exactly one word per input word, in order, with the
// result bounds, a saturation flag and a divide-by-zero flag.
// Each word passes through 2*FRAC_BITS+1 stages
// of the restoring reciprocal pipeline, one stage each for capture and
// rounding of the reciprocal, then three product stages (multiply, scale and
// saturate, bound selection). Multiply words travel the same path.
// Throughput is one word per cycle while no stall on rsp_ready holds it.
// A stall on rsp_ready freezes the whole pipeline; req_ready drops in the
// same cycle, and no word is lost or repeated. The last stage is the output
// register, so a new word is taken whenever the output is empty or drains.
// Reset clears every valid bit and no other state.
module interval_multiply_divide_top #(
   parameter int WORD_BITS = imd_pkg::WORD_BITS_DEF,
   parameter int FRAC_BITS = imd_pkg::FRAC_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_opcode,
   input  logic signed [WORD_BITS-1:0] req_a_lo,
   input  logic signed [WORD_BITS-1:0] req_a_hi,
   input  logic signed [WORD_BITS-1:0] req_b_lo,
   input  logic signed [WORD_BITS-1:0] req_b_hi,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [WORD_BITS-1:0] rsp_res_lo,
   output logic signed [WORD_BITS-1:0] rsp_res_hi,
   output logic                        rsp_overflow,
   output logic                        rsp_div_zero
);
   import imd_pkg::*;

   localparam int LR = 2 * FRAC_BITS + 3;

   logic adv;

   logic                        vld_ff [LR];
   logic                        op_ff  [LR];
   logic signed [WORD_BITS-1:0] al_ff  [LR];
   logic signed [WORD_BITS-1:0] ah_ff  [LR];
   logic signed [WORD_BITS-1:0] bl_ff  [LR];
   logic signed [WORD_BITS-1:0] bh_ff  [LR];

   logic signed [WORD_BITS-1:0] r_lo, r_hi, m_bl, m_bh;
   logic                        ov_rlo, ov_rhi, is_div, dz;
   ctl_type                     ctl_in, ctl_out;

   assign adv       = rsp_ready || !rsp_valid;
   assign req_ready = adv;

   // hold the operands alongside the reciprocal pipeline
   for (genvar g = 0; g < LR; g++) begin : g_delay
      logic                        v_prev, o_prev;
      logic signed [WORD_BITS-1:0] al_prev, ah_prev, bl_prev, bh_prev;
      if (g == 0) begin : g_first
         assign v_prev  = req_valid;
         assign o_prev  = req_opcode;
         assign al_prev = req_a_lo;
         assign ah_prev = req_a_hi;
         assign bl_prev = req_b_lo;
         assign bh_prev = req_b_hi;
      end else begin : g_next
         assign v_prev  = vld_ff[g-1];
         assign o_prev  = op_ff[g-1];
         assign al_prev = al_ff[g-1];
         assign ah_prev = ah_ff[g-1];
         assign bl_prev = bl_ff[g-1];
         assign bh_prev = bh_ff[g-1];
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[g] <= 1'b0;
         end else if (adv) begin
            vld_ff[g] <= v_prev;
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            op_ff[g] <= o_prev;
            al_ff[g] <= al_prev;
            ah_ff[g] <= ah_prev;
            bl_ff[g] <= bl_prev;
            bh_ff[g] <= bh_prev;
         end
      end
   end

   // the new low bound is 1/b_hi, the new high bound 1/b_lo
   imd_recip #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_recip_lo (
      .clock (clock),
      .en    (adv),
      .b     (req_b_hi),
      .recip (r_lo),
      .ov    (ov_rlo)
   );

   imd_recip #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_recip_hi (
      .clock (clock),
      .en    (adv),
      .b     (req_b_lo),
      .recip (r_hi),
      .ov    (ov_rhi)
   );

   always_comb begin
      is_div = (op_ff[LR-1] == OP_DIV);
      dz     = is_div && ((bl_ff[LR-1] == '0) || (bh_ff[LR-1] == '0) ||
               (bl_ff[LR-1][WORD_BITS-1] && !bh_ff[LR-1][WORD_BITS-1]));
      m_bl   = is_div ? r_lo : bl_ff[LR-1];
      m_bh   = is_div ? r_hi : bh_ff[LR-1];
      ctl_in.valid = vld_ff[LR-1];
      ctl_in.dz    = dz;
      ctl_in.ov    = is_div && !dz && (ov_rlo || ov_rhi);
   end

   imd_mul #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_mul (
      .clock   (clock),
      .reset   (reset),
      .en      (adv),
      .ctl_in  (ctl_in),
      .al      (al_ff[LR-1]),
      .ah      (ah_ff[LR-1]),
      .bl      (m_bl),
      .bh      (m_bh),
      .ctl_out (ctl_out),
      .res_lo  (rsp_res_lo),
      .res_hi  (rsp_res_hi)
   );

   assign rsp_valid    = ctl_out.valid;
   assign rsp_overflow = ctl_out.ov;
   assign rsp_div_zero = ctl_out.dz;

`ifndef ASSERT_OFF
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped during stall");
   a_ready_only_on_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled while output free");
   a_mul_no_dz: assert property (@(posedge clock) disable iff (reset)
      vld_ff[LR-1] && !is_div |-> !dz)
      else $error("multiply flagged as divide by zero");
`endif

endmodule
